// ===== rtl/core/dsip_pkg.sv =====
`default_nettype none

package dsip_pkg;

  localparam int MAX_INTEGER_BYTES_DEF = 512;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [15:0] BUF_LEN_RESET = 16'hFFFF;

  localparam logic [7:0] TAG_SEQUENCE = 8'h30;
  localparam logic [7:0] TAG_INTEGER = 8'h02;
  localparam logic [7:0] LEN_LONG_FLAG = 8'h80;

  localparam logic [1:0] KIND_SEQ_DONE = 2'd0;
  localparam logic [1:0] KIND_INT_BYTE = 2'd1;
  localparam logic [1:0] KIND_INT_EMPTY = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [2:0] ERR_BAD_TAG = 3'd0;
  localparam logic [2:0] ERR_LEN_WIDE = 3'd1;
  localparam logic [2:0] ERR_ZERO_LEN = 3'd2;
  localparam logic [2:0] ERR_PAST_END = 3'd3;
  localparam logic [2:0] ERR_INT_LONG = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       mode;
    logic       restart;
  } dsip_in_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [15:0] out_length;
    logic        out_last;
    logic [9:0]  kept_count;
    logic [2:0]  error_code;
  } dsip_out_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       mode;
    logic       restart;
    logic       tag_ok;
    logic       is_long;
    logic       too_wide;
    logic [1:0] len_n;
    logic       is_zero;
  } dsip_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/dsip_fifo.sv =====
`default_nettype none

module dsip_fifo (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  wr_valid,
  output logic                 wr_ready,
  input  dsip_pkg::dsip_entry_t wr_data,
  output logic                 rd_valid,
  input  wire                  rd_ready,
  output dsip_pkg::dsip_entry_t rd_data
);
  import dsip_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  dsip_entry_t     mem_r [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push, pop;

  assign wr_ready = (count_r != CW'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dsip_front.sv =====
`default_nettype none

module dsip_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  dsip_pkg::dsip_in_t    in_data,
  output logic                  q_valid,
  input  wire                   q_ready,
  output dsip_pkg::dsip_entry_t q_data
);
  import dsip_pkg::*;

  dsip_entry_t ent;
  logic [7:0]  n_full;

  always_comb begin
    n_full       = in_data.data_byte - LEN_LONG_FLAG;
    ent.data_byte = in_data.data_byte;
    ent.mode      = in_data.mode;
    ent.restart   = in_data.restart;
    ent.tag_ok    = in_data.mode ? (in_data.data_byte == TAG_INTEGER)
                                 : (in_data.data_byte == TAG_SEQUENCE);
    ent.is_long   = in_data.data_byte[7];
    ent.too_wide  = (n_full > 8'd2);
    ent.len_n     = n_full[1:0];
    ent.is_zero   = (in_data.data_byte == 8'd0);
  end

  dsip_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_data  (ent),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/dsip_back.sv =====
`default_nettype none

module dsip_back #(
  parameter int MAX_INTEGER_BYTES = dsip_pkg::MAX_INTEGER_BYTES_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire [15:0]            buffer_length,
  input  wire                   q_valid,
  output logic                  q_ready,
  input  dsip_pkg::dsip_entry_t q_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output dsip_pkg::dsip_out_t   out_data
);
  import dsip_pkg::*;

  localparam int KW = $clog2(MAX_INTEGER_BYTES + 1);

  localparam logic [2:0] PH_TAG     = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_LONGLEN = 3'd2;
  localparam logic [2:0] PH_CONTENT = 3'd3;
  localparam logic [2:0] PH_ERROR   = 3'd4;

  logic [2:0]    phase_r, phase_nxt;
  logic          is_int_r, is_int_nxt;
  logic [16:0]   pos_r, pos_nxt;
  logic [1:0]    lenleft_r, lenleft_nxt;
  logic [15:0]   content_r, content_nxt;
  logic [KW-1:0] kept_r, kept_nxt;
  logic          out_valid_r;
  dsip_out_t     out_data_r;

  logic [2:0]    phase_c;
  logic [16:0]   pos_c;
  logic [1:0]    lenleft_c;
  logic [15:0]   content_c;
  logic [KW-1:0] kept_c;
  logic          past, hdr, fail;
  logic [2:0]    fail_code;
  logic [15:0]   hdr_len;
  logic          res_valid;
  dsip_out_t     res;
  logic          pop;

  assign q_ready   = !out_valid_r || out_ready;
  assign pop       = q_valid && q_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    phase_c   = q_data.restart ? PH_TAG : phase_r;
    pos_c     = q_data.restart ? '0 : pos_r;
    lenleft_c = q_data.restart ? '0 : lenleft_r;
    content_c = q_data.restart ? '0 : content_r;
    kept_c    = q_data.restart ? '0 : kept_r;

    phase_nxt   = phase_c;
    is_int_nxt  = is_int_r;
    pos_nxt     = pos_c;
    lenleft_nxt = lenleft_c;
    content_nxt = content_c;
    kept_nxt    = kept_c;
    past        = 1'b0;
    hdr         = 1'b0;
    hdr_len     = '0;
    fail        = 1'b0;
    fail_code   = ERR_BAD_TAG;
    res_valid   = 1'b0;
    res         = '0;

    if (phase_c <= PH_CONTENT) begin
      pos_nxt = pos_c + 17'd1;
      past    = (pos_nxt > {1'b0, buffer_length});
      case (phase_c)
        PH_TAG: begin
          if (!q_data.tag_ok) begin
            fail      = 1'b1;
            fail_code = ERR_BAD_TAG;
          end else if (past) begin
            fail      = 1'b1;
            fail_code = ERR_PAST_END;
          end else begin
            is_int_nxt = q_data.mode;
            if (q_data.mode) begin
              kept_nxt = '0;
            end
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (past) begin
            fail      = 1'b1;
            fail_code = ERR_PAST_END;
          end else if (q_data.is_long) begin
            if (q_data.too_wide) begin
              fail      = 1'b1;
              fail_code = ERR_LEN_WIDE;
            end else begin
              content_nxt = '0;
              lenleft_nxt = q_data.len_n;
              if (q_data.len_n == 2'd0) begin
                hdr = 1'b1;
              end else begin
                phase_nxt = PH_LONGLEN;
              end
            end
          end else if (q_data.is_zero) begin
            fail      = 1'b1;
            fail_code = ERR_ZERO_LEN;
          end else begin
            content_nxt = {8'd0, q_data.data_byte};
            hdr         = 1'b1;
          end
        end
        PH_LONGLEN: begin
          if (past) begin
            fail      = 1'b1;
            fail_code = ERR_PAST_END;
          end else begin
            content_nxt = {content_c[7:0], q_data.data_byte};
            lenleft_nxt = lenleft_c - 2'd1;
            hdr         = (lenleft_nxt == 2'd0);
          end
        end
        PH_CONTENT: begin
          if (past) begin
            fail      = 1'b1;
            fail_code = ERR_PAST_END;
          end else begin
            content_nxt = content_c - 16'd1;
            if (kept_c == '0 && q_data.is_zero) begin
              if (content_nxt == '0) begin
                phase_nxt     = PH_TAG;
                res_valid     = 1'b1;
                res.out_kind  = KIND_INT_EMPTY;
                res.out_last  = 1'b1;
              end
            end else if (kept_c >= KW'(MAX_INTEGER_BYTES)) begin
              fail      = 1'b1;
              fail_code = ERR_INT_LONG;
            end else begin
              kept_nxt       = kept_c + 1'b1;
              res_valid      = 1'b1;
              res.out_kind   = KIND_INT_BYTE;
              res.out_byte   = q_data.data_byte;
              res.out_last   = (content_nxt == '0);
              res.kept_count = 10'((KW + 10)'(kept_nxt));
              if (content_nxt == '0) begin
                phase_nxt = PH_TAG;
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_ERROR;
        end
      endcase

      if (hdr) begin
        hdr_len = content_nxt;
        if (!is_int_r) begin
          phase_nxt      = PH_TAG;
          res_valid      = 1'b1;
          res.out_kind   = KIND_SEQ_DONE;
          res.out_length = hdr_len;
        end else if (hdr_len == '0) begin
          phase_nxt    = PH_TAG;
          res_valid    = 1'b1;
          res.out_kind = KIND_INT_EMPTY;
          res.out_last = 1'b1;
        end else begin
          phase_nxt = PH_CONTENT;
        end
      end

      if (fail) begin
        phase_nxt      = PH_ERROR;
        res_valid      = 1'b1;
        res            = '0;
        res.out_kind   = KIND_ERROR;
        res.kept_count = 10'((KW + 10)'(kept_c));
        res.error_code = fail_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TAG;
      is_int_r    <= 1'b0;
      pos_r       <= '0;
      lenleft_r   <= '0;
      content_r   <= '0;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r   <= phase_nxt;
        is_int_r  <= is_int_nxt;
        pos_r     <= pos_nxt;
        lenleft_r <= lenleft_nxt;
        content_r <= content_nxt;
        kept_r    <= kept_nxt;
      end
      if (pop && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/der_sequence_integer_parser.sv =====
// DER SEQUENCE / INTEGER parser, one byte word per cycle when not stalled.
// Input channel in_valid/in_ready/in_data carries a data byte, the element
// kind expected at an element start (mode) and a restart flag for the first
// byte of a new buffer. Output channel out_valid/out_ready/out_data gives at
// most one result word per input word: sequence length, kept integer byte,
// empty-integer marker, or an error with its code.
// cfg_we/cfg_wdata writes the buffer length; write only while idle.
// A front stage classifies bytes into a two-entry queue; a back stage runs
// the header/content state machine and loads the output register.
// A result word is registered: its input word waits in the queue, then the
// back stage loads the result into the output register.
// Throughput: one word per cycle while the output is not stalled, limited
// by the single state update in the back stage. A stalled receiver holds
// the output register, and the queue fills both entries before in_ready drops.
// Reset (rst_n low, synchronous) empties the queue and output, clears the
// parser state and sets buffer length to 65535. After an error all words are
// dropped until one arrives with restart set.
`default_nettype none

module der_sequence_integer_parser #(
  parameter int MAX_INTEGER_BYTES = dsip_pkg::MAX_INTEGER_BYTES_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  dsip_pkg::dsip_in_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output dsip_pkg::dsip_out_t out_data,
  input  wire                 cfg_we,
  input  wire [15:0]          cfg_wdata
);
  import dsip_pkg::*;

  logic [15:0] buf_len_r;
  logic        q_valid, q_ready;
  dsip_entry_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_len_r <= BUF_LEN_RESET;
    end else if (cfg_we) begin
      buf_len_r <= cfg_wdata;
    end
  end

  dsip_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  dsip_back #(
    .MAX_INTEGER_BYTES (MAX_INTEGER_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .buffer_length (buf_len_r),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_data        (q_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule

`default_nettype wire
